/* rtl/pol_pkg.sv */
// Shared types and codes for the positional ordered list.
package pol_pkg;

  // Field widths of the request and response channels
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned ITEM_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_END   = 3'd4,
    OP_REM_POS   = 3'd5
  } op_e;

  // Response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Request payload
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_id;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [ITEM_W-1:0]  removed_id;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count_after;
  } rsp_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic step;  // a request is accepted this cycle
    logic ins;   // open a slot at the target and shift the tail right
    logic rem;   // close the target slot and shift the tail left
  } cell_ctl_t;

endpackage

/* rtl/pol_cell.sv */
// One list cell: holds one entry and trades it with its neighbors.
module pol_cell #(
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned IDX_W   = 6,
  parameter int unsigned INDEX   = 0
) (
  input  logic               clk_i,
  input  pol_pkg::cell_ctl_t ctl_i,
  input  logic [IDX_W-1:0]   at_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic [ID_BITS-1:0] left_i,
  input  logic [ID_BITS-1:0] right_i,
  output logic [ID_BITS-1:0] val_o,
  output logic [ID_BITS-1:0] pick_o
);
  import pol_pkg::*;

  logic [ID_BITS-1:0] val_d, val_q;
  logic [ID_BITS-1:0] pick_d, pick_q;
  logic               at_eq, at_le;

  // Compare the target position with this cell's place
  assign at_eq = (at_i == IDX_W'(INDEX));
  assign at_le = (at_i <= IDX_W'(INDEX));

  // Pick the next entry: load, take from the left, take from the right or hold
  always_comb begin
    val_d  = val_q;
    pick_d = pick_q;
    if (ctl_i.step) begin
      pick_d = (ctl_i.rem && at_eq) ? val_q : '0;
      if (ctl_i.ins && at_le) begin
        val_d = at_eq ? id_i : left_i;
      end else if (ctl_i.rem && at_le) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pick_q <= pick_d;
  end

  assign val_o  = val_q;
  assign pick_o = pick_q;

endmodule

/* rtl/pol_or_tree.sv */
// Two-level OR reduction that gathers the removed entry from the cells.
module pol_or_tree #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [ID_BITS-1:0] picks_i [CAPACITY],
  output logic [ID_BITS-1:0] result_o
);
  import pol_pkg::*;

  localparam int unsigned GROUP  = 32;
  localparam int unsigned GROUPS = (CAPACITY + GROUP - 1) / GROUP;

  logic [ID_BITS-1:0] grp_d [GROUPS];
  logic [ID_BITS-1:0] grp_q [GROUPS];

  // Fold each group of cells; at most one cell holds a nonzero pick
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | picks_i[g * GROUP + k];
        end
      end
    end
  end

  // Hold group sums while the downstream stage stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  // Fold the group sums
  always_comb begin
    result_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      result_o = result_o | grp_q[g];
    end
  end

endmodule

/* rtl/positional_ordered_list_core.sv */
// Top level of the positional ordered list: control, cell chain and response path.
//
// Bounded ordered list of identifiers kept in a chain of CAPACITY cells,
// entry 0 at the front. Each request on the in channel (valid/stall, payload
// pol_pkg::req_t) inserts at the front, the end or a position, or removes
// from the front, the end or a position. Every request gives exactly one
// response on the out channel (payload pol_pkg::rsp_t): removed identifier,
// status and the entry count after the request.
// Cells at and past the target shift one place in the cycle a successful
// request is accepted, so one request is taken per cycle while in_stall_o
// is low. A response passes the cell pick, group OR and output registers.
// The removed entry is gathered by a registered OR tree over the cells.
// When the receiver stalls, responses back up through the three stages;
// once all are full, in_stall_o rises and the list holds still.
// Reset clears the entry count and all stage valids; cell contents stay
// undefined, and only entries below the count are ever read.
// Unused operation codes give status done, no removal and the same count.
module positional_ordered_list_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pol_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pol_pkg::rsp_t out_rsp_o
);
  import pol_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]   count_d, count_q;
  logic [PW-1:0]      count_w, pos_w, at_w;
  logic               full, empty, is_ins, is_rem, ok;
  status_e            status;
  cell_ctl_t          ctl;
  logic               accept;
  logic [ID_BITS-1:0] new_id;

  logic               v1_q, v2_q, vo_q;
  logic               rdy1, rdy2, rdyo;
  status_e            st1_q, st2_q;
  logic [COUNT_W-1:0] cnt1_q, cnt2_q;
  rsp_t               rsp_q;

  logic [ID_BITS-1:0] vals  [CAPACITY];
  logic [ID_BITS-1:0] picks [CAPACITY];
  logic [ID_BITS-1:0] removed;

  // Advance the response pipeline
  assign rdyo   = !vo_q || !out_stall_i;
  assign rdy2   = !v2_q || rdyo;
  assign rdy1   = !v1_q || rdy2;
  assign accept = in_valid_i && rdy1;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = vo_q;
  assign out_rsp_o   = rsp_q;

  // Decode the request against the current count
  assign count_w = PW'(count_q);
  assign pos_w   = PW'(in_req_i.position);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign new_id  = ID_BITS'(in_req_i.item_id);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    at_w   = '0;
    unique case (op_e'(in_req_i.operation))
      OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      OP_INS_END: begin
        is_ins = 1'b1;
        at_w   = count_w;
      end
      OP_INS_POS: begin
        is_ins = 1'b1;
        at_w   = pos_w;
      end
      OP_REM_FRONT: begin
        is_rem = 1'b1;
      end
      OP_REM_END: begin
        is_rem = 1'b1;
        at_w   = empty ? '0 : count_w - PW'(1);
      end
      OP_REM_POS: begin
        is_rem = 1'b1;
        at_w   = pos_w;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  // Check capacity first, then the position
  always_comb begin
    ok     = 1'b1;
    status = ST_DONE;
    if (is_ins) begin
      if (full) begin
        ok     = 1'b0;
        status = ST_FULL;
      end else if (at_w > count_w) begin
        ok     = 1'b0;
        status = ST_RANGE;
      end
    end else if (is_rem) begin
      if (empty || at_w >= count_w) begin
        ok     = 1'b0;
        status = ST_RANGE;
      end
    end
  end

  assign ctl.step = accept;
  assign ctl.ins  = is_ins && ok;
  assign ctl.rem  = is_rem && ok;

  // Update the count
  always_comb begin
    count_d = count_q;
    if (accept && ctl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (accept && ctl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end
    pol_cell #(
      .ID_BITS (ID_BITS),
      .IDX_W   (IDX_W),
      .INDEX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .at_i    (at_w[IDX_W-1:0]),
      .id_i    (new_id),
      .left_i  (left_v),
      .right_i (right_v),
      .val_o   (vals[i]),
      .pick_o  (picks[i])
    );
  end

  // Gather the removed entry
  pol_or_tree #(
    .ID_BITS  (ID_BITS),
    .CAPACITY (CAPACITY)
  ) u_or_tree (
    .clk_i    (clk_i),
    .en_i     (rdy2),
    .picks_i  (picks),
    .result_o (removed)
  );

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdyo) begin
        vo_q <= v2_q;
      end
    end
  end

  // Carry status and count alongside the removed entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st1_q  <= status;
      cnt1_q <= COUNT_W'(count_d);
    end
    if (rdy2) begin
      st2_q  <= st1_q;
      cnt2_q <= cnt1_q;
    end
    if (rdyo) begin
      rsp_q.removed_id  <= ITEM_W'(removed);
      rsp_q.status      <= st2_q;
      rsp_q.count_after <= cnt2_q;
    end
  end

  // Count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A successful insert raises the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctl.ins) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not raise count");

  // A refused request leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ctl.ins && !ctl.rem) |=> (count_q == $past(count_q)))
    else $error("refused request changed count");

  // A failed response carries no identifier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && rsp_q.status != ST_DONE) |-> (rsp_q.removed_id == '0))
    else $error("failed response with nonzero identifier");

  // A full pipeline with a stalled receiver stalls the sender
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && vo_q && out_stall_i) |-> in_stall_o)
    else $error("request taken while pipeline is blocked");

endmodule
